// ===== rtl/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg
// shared types, codes, constant tables and divide-by-constant helpers
// ----------------------------------------------------------------------------
package rcm_pkg;

    localparam int PIPE_STAGES = 12;
    localparam int DB_ENTRIES  = 100;

    typedef struct packed {
        logic              link_up;
        logic signed [15:0] wheel_raw;
        logic [7:0]        gas_trigger;
        logic [7:0]        brake_trigger;
        logic [5:0]        button_bits;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] steer_value;
        logic signed [15:0] throttle_axis;
        logic [7:0]        throttle_level;
        logic [7:0]        brake_level;
        logic [2:0]        result_kind;
        logic              paddle_left_on;
        logic              paddle_right_on;
        logic [5:0]        buttons_out;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_DEADBAND    = 3'd0,
        CFG_STEER_EXPO  = 3'd1,
        CFG_THR_EXPO    = 3'd2,
        CFG_END_LEFT    = 3'd3,
        CFG_END_RIGHT   = 3'd4,
        CFG_THR_END     = 3'd5,
        CFG_BRAKE_END   = 3'd6,
        CFG_MODE_INV    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_FAILSAFE = 3'd0,
        KIND_COMBINED = 3'd1,
        KIND_SEPARATE = 3'd2,
        KIND_THR_ONLY = 3'd3,
        KIND_NONE     = 3'd4
    } t_kind;

    localparam logic [1:0] MODE_COMBINED = 2'd0;
    localparam logic [1:0] MODE_SEPARATE = 2'd1;
    localparam logic [1:0] MODE_THR_ONLY = 2'd2;
    localparam logic [1:0] MODE_NONE     = 2'd3;

    localparam logic [6:0] PCT_FULL    = 7'd100;
    localparam logic [6:0] DB_MAX      = 7'd99;
    localparam logic [7:0] LEVEL_MAX   = 8'd255;

    // reciprocals for exact truncating division over the value ranges used here
    localparam logic [22:0] RECIP_100 = 23'd5368710;   // ceil(2^29 / 100)
    localparam logic [23:0] RECIP_255 = 24'd8421505;   // ceil(2^31 / 255)

    typedef logic [14:0] t_db_thr_arr [DB_ENTRIES];
    typedef logic [15:0] t_db_div_arr [DB_ENTRIES];
    typedef logic [21:0] t_db_rcp_arr [DB_ENTRIES];

    // floor(y / 100), exact for y < 2^22
    function automatic logic [15:0] f_div100(input logic [21:0] y);
        logic [44:0] prod;
        prod = y * RECIP_100;
        return prod[44:29];
    endfunction

    // floor(y / 255), exact for y < 2^23
    function automatic logic [15:0] f_div255(input logic [22:0] y);
        logic [46:0] prod;
        prod = y * RECIP_255;
        return prod[46:31];
    endfunction

    // floor(2^30 / den) by restoring division, used only to fill a table
    function automatic logic [21:0] f_recip30(input logic [15:0] den);
        logic [30:0] num;
        logic [30:0] quo;
        logic [16:0] rem;
        num = 31'h4000_0000;
        quo = '0;
        rem = '0;
        for (int b = 30; b >= 0; b--) begin
            rem = {rem[15:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo[21:0];
    endfunction

    function automatic t_db_thr_arr f_build_thr();
        t_db_thr_arr arr;
        logic [15:0] thr;
        for (int i = 0; i < DB_ENTRIES; i++) begin
            thr    = f_div100(22'(i * 32768));
            arr[i] = thr[14:0];
        end
        return arr;
    endfunction

    function automatic t_db_div_arr f_build_div();
        t_db_div_arr arr;
        logic [15:0] thr;
        for (int i = 0; i < DB_ENTRIES; i++) begin
            thr    = f_div100(22'(i * 32768));
            arr[i] = 16'd32768 - thr;
        end
        return arr;
    endfunction

    function automatic t_db_rcp_arr f_build_rcp();
        t_db_rcp_arr arr;
        logic [15:0] thr;
        logic [15:0] dv;
        for (int i = 0; i < DB_ENTRIES; i++) begin
            thr    = f_div100(22'(i * 32768));
            dv     = 16'd32768 - thr;
            arr[i] = f_recip30(dv);
        end
        return arr;
    endfunction

    localparam t_db_thr_arr DB_THR = f_build_thr();
    localparam t_db_div_arr DB_DIV = f_build_div();
    localparam t_db_rcp_arr DB_RCP = f_build_rcp();

endpackage

// ===== rtl/rcm_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcm_pipe_ctrl
// valid bits and per-stage load enables, bubbles collapse under stall
// ----------------------------------------------------------------------------
module rcm_pipe_ctrl #(
    parameter int STAGES = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    output logic [STAGES-1:0] o_en,
    output logic              o_valid
);

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_v;
    logic [STAGES-1:0] inv_v;

    // a stage loads if it or any stage downstream of it holds a hole, or the sink takes
    always_comb begin
        inv_v = ~r_v;
        for (int k = 0; k < STAGES; k++) begin
            o_en[k] = !i_stall || ((inv_v >> k) != '0);
        end
    end

    assign n_v = {r_v[STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (n_v & o_en) | (r_v & ~o_en);
        end
    end

    assign o_valid = r_v[STAGES-1];

endmodule

// ===== rtl/rcm_expo.sv =====
// ----------------------------------------------------------------------------
// rcm_expo
// six-stage cubic expo on a sign/magnitude value, q1.15 with q1.30 cube
// ----------------------------------------------------------------------------
module rcm_expo import rcm_pkg::*; (
    input  logic              i_clk,
    input  logic [5:0]        i_en,
    input  logic [15:0]       i_mag,
    input  logic              i_neg,
    input  logic signed [7:0] i_expo,
    output logic [15:0]       o_mag,
    output logic              o_neg
);

    logic [7:0]  abs_e;
    logic [6:0]  mag_e;
    logic        e_neg;
    logic        e_zero;

    logic [29:0] r1_sq;
    logic [15:0] r1_mag, r2_mag, r3_mag, r4_mag, r5_mag;
    logic        r1_neg, r2_neg, r3_neg, r4_neg, r5_neg;
    logic [29:0] r2_c;
    logic [21:0] r3_p1;
    logic [36:0] r3_p2;
    logic [37:0] r4_a;
    logic        r4_ineg, r5_ineg;
    logic [21:0] r5_y;
    logic [15:0] r6_mag;
    logic        r6_neg;

    logic [44:0]        cube;
    logic [36:0]        hi;
    logic signed [38:0] inner;
    logic [38:0]        inner_abs;
    logic [52:0]        scaled;

    assign abs_e  = i_expo[7] ? 8'(-i_expo) : i_expo;
    assign mag_e  = abs_e[6:0];
    assign e_neg  = i_expo[7];
    assign e_zero = (i_expo == 8'sd0);

    assign cube      = r1_sq * r1_mag[14:0];
    assign hi        = {r3_p1, 15'b0};
    assign inner     = e_neg ? signed'({2'b0, hi} - {2'b0, r3_p2})
                             : signed'({2'b0, hi} + {2'b0, r3_p2});
    assign inner_abs = inner[38] ? 39'(-inner) : inner;
    assign scaled    = {r4_a, 15'b0} - {15'b0, r4_a};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_sq  <= i_mag[14:0] * i_mag[14:0];
            r1_mag <= i_mag;
            r1_neg <= i_neg;
        end
        if (i_en[1]) begin
            r2_c   <= cube[44:15];
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
        end
        if (i_en[2]) begin
            r3_p1  <= r2_mag[14:0] * (PCT_FULL - mag_e);
            r3_p2  <= r2_c * mag_e;
            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
        end
        if (i_en[3]) begin
            r4_a    <= inner_abs[37:0];
            r4_ineg <= inner[38];
            r4_mag  <= r3_mag;
            r4_neg  <= r3_neg;
        end
        if (i_en[4]) begin
            r5_y    <= scaled[51:30];
            r5_ineg <= r4_ineg;
            r5_mag  <= r4_mag;
            r5_neg  <= r4_neg;
        end
        if (i_en[5]) begin
            r6_mag <= e_zero ? r5_mag : f_div100(r5_y);
            r6_neg <= e_zero ? r5_neg : (r5_neg ^ r5_ineg);
        end
    end

    assign o_mag = r6_mag;
    assign o_neg = r6_neg;

endmodule

// ===== rtl/rcm_endpoint.sv =====
// ----------------------------------------------------------------------------
// rcm_endpoint
// two-stage percent endpoint scaling with optional sign flip
// ----------------------------------------------------------------------------
module rcm_endpoint import rcm_pkg::*; (
    input  logic               i_clk,
    input  logic [1:0]         i_en,
    input  logic [15:0]        i_mag,
    input  logic               i_neg,
    input  logic               i_flip,
    input  logic [6:0]         i_pct_pos,
    input  logic [6:0]         i_pct_neg,
    output logic signed [15:0] o_value
);

    logic        is_neg;
    logic [6:0]  pct;
    logic [21:0] r1_prod;
    logic [15:0] r1_mag;
    logic        r1_pass;
    logic        r1_sign;
    logic [15:0] q;
    logic signed [15:0] r2_value;

    assign is_neg = i_neg && (i_mag != 16'd0);
    assign pct    = is_neg ? i_pct_neg : i_pct_pos;
    assign q      = r1_pass ? r1_mag : f_div100(r1_prod);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_prod <= i_mag[14:0] * pct;
            r1_mag  <= i_mag;
            r1_pass <= (pct >= PCT_FULL);
            r1_sign <= is_neg ^ i_flip;
        end
        if (i_en[1]) begin
            r2_value <= r1_sign ? signed'(16'(-q)) : signed'(q);
        end
    end

    assign o_value = r2_value;

endmodule

// ===== rtl/rc_axis_trigger_mixer.sv =====
// result valid once the item has passed the 12 register stages,
//   and taken when the output is not stalled
// throughput: one item per cycle unless stalled; each stage has its own valid bit
// a stalled output holds its item; holes in the pipeline still fill, so input is taken
//   while a finished result waits as long as any stage is empty
// reset (synchronous, active low) clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
// rc_axis_trigger_mixer
// wheel and trigger conditioning: unfold, deadband, expo, invert, endpoints,
// throttle mode mixing and button pass-through, deep pipeline
// ----------------------------------------------------------------------------
module rc_axis_trigger_mixer import rcm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    // sideband that rides along the pipeline next to the arithmetic lanes
    typedef struct packed {
        logic       link;
        logic [2:0] kind;
        logic [7:0] tl;
        logic [7:0] bl;
        logic [5:0] btn;
    } t_side;

    // ---------------- configuration registers ----------------
    logic [6:0]        r_cfg_db;
    logic signed [7:0] r_cfg_sexpo;
    logic signed [7:0] r_cfg_texpo;
    logic [6:0]        r_cfg_endl;
    logic [6:0]        r_cfg_endr;
    logic [6:0]        r_cfg_tend;
    logic [6:0]        r_cfg_bend;
    logic [3:0]        r_cfg_mode;

    logic [6:0]        cfg_pct;
    logic [6:0]        cfg_db;
    logic signed [7:0] cfg_sdata;
    logic signed [7:0] cfg_expo;

    // percent fields saturate at write time so the datapath sees legal values
    assign cfg_pct   = (i_cfg_data[6:0] > PCT_FULL) ? PCT_FULL : i_cfg_data[6:0];
    assign cfg_db    = (i_cfg_data[6:0] > DB_MAX) ? DB_MAX : i_cfg_data[6:0];
    assign cfg_sdata = signed'(i_cfg_data);
    assign cfg_expo  = (cfg_sdata > 8'sd100)  ? 8'sd100 :
                       (cfg_sdata < -8'sd100) ? -8'sd100 : cfg_sdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_db    <= '0;
            r_cfg_sexpo <= '0;
            r_cfg_texpo <= '0;
            r_cfg_endl  <= PCT_FULL;
            r_cfg_endr  <= PCT_FULL;
            r_cfg_tend  <= PCT_FULL;
            r_cfg_bend  <= PCT_FULL;
            r_cfg_mode  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEADBAND:   r_cfg_db    <= cfg_db;
                CFG_STEER_EXPO: r_cfg_sexpo <= cfg_expo;
                CFG_THR_EXPO:   r_cfg_texpo <= cfg_expo;
                CFG_END_LEFT:   r_cfg_endl  <= cfg_pct;
                CFG_END_RIGHT:  r_cfg_endr  <= cfg_pct;
                CFG_THR_END:    r_cfg_tend  <= cfg_pct;
                CFG_BRAKE_END:  r_cfg_bend  <= cfg_pct;
                CFG_MODE_INV:   r_cfg_mode  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic [1:0] mode;
    logic       steer_inv;
    logic       thr_inv;
    assign mode      = r_cfg_mode[1:0];
    assign steer_inv = r_cfg_mode[2];
    assign thr_inv   = r_cfg_mode[3];

    // ---------------- pipeline control ----------------
    logic [PIPE_STAGES-1:0] en;
    logic                   pipe_valid;

    rcm_pipe_ctrl #(
        .STAGES (PIPE_STAGES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_stall (i_out_stall),
        .o_en    (en),
        .o_valid (pipe_valid)
    );

    assign o_in_stall  = !en[0];
    assign o_out_valid = pipe_valid;

    // ---------------- stage 0: input capture ----------------
    t_in_item r0_item;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_item <= i_in_item;
        end
    end

    // ---------------- stage 1: unfold, deadband cut, trigger difference ----------------
    logic signed [16:0] w17;
    logic signed [16:0] v17;
    logic [14:0]        av;
    logic [14:0]        db_thr;
    logic [14:0]        db_mag;
    logic [29:0]        db_num;
    logic signed [8:0]  tdiff;
    logic [7:0]         tdiff_abs;
    logic [22:0]        t_scaled;

    // wheel reports center at +-max and full lock at zero
    assign w17       = 17'(r0_item.wheel_raw);
    assign v17       = r0_item.wheel_raw[15] ? (-17'sd32767 - w17) : (17'sd32767 - w17);
    assign av        = v17[16] ? 15'(-v17) : v17[14:0];
    assign db_thr    = DB_THR[r_cfg_db];
    assign db_mag    = (av >= db_thr) ? (av - db_thr) : 15'd0;
    // times 32767 as shift and subtract
    assign db_num    = {db_mag, 15'b0} - {15'b0, db_mag};
    assign tdiff     = signed'({1'b0, r0_item.gas_trigger}) - signed'({1'b0, r0_item.brake_trigger});
    assign tdiff_abs = tdiff[8] ? 8'(-tdiff) : tdiff[7:0];
    assign t_scaled  = {tdiff_abs, 15'b0} - {15'b0, tdiff_abs};

    logic [29:0] r1_num;
    logic [14:0] r1_av;
    logic        r1_sneg;
    logic [22:0] r1_ty;
    logic        r1_tneg;
    logic [14:0] r1_pg;
    logic [14:0] r1_pb;
    logic        r1_link;
    logic [5:0]  r1_btn;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_num  <= db_num;
            r1_av   <= av;
            r1_sneg <= v17[16];
            r1_ty   <= t_scaled;
            r1_tneg <= tdiff[8];
            r1_pg   <= r0_item.gas_trigger * r_cfg_tend;
            r1_pb   <= r0_item.brake_trigger * r_cfg_bend;
            r1_link <= r0_item.link_up;
            r1_btn  <= r0_item.button_bits;
        end
    end

    // ---------------- stage 2: reciprocal estimates ----------------
    logic [51:0] db_est;
    logic [15:0] tl_div;
    logic [15:0] bl_div;
    assign db_est = r1_num * DB_RCP[r_cfg_db];
    assign tl_div = f_div100({7'b0, r1_pg});
    assign bl_div = f_div100({7'b0, r1_pb});

    logic [15:0] r2_qe;
    logic [29:0] r2_num;
    logic [14:0] r2_av;
    logic        r2_sneg;
    logic [15:0] r2_tmag;
    logic        r2_tneg;
    logic [7:0]  r2_tl;
    logic [7:0]  r2_bl;
    logic        r2_link;
    logic [5:0]  r2_btn;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_qe   <= db_est[45:30];
            r2_num  <= r1_num;
            r2_av   <= r1_av;
            r2_sneg <= r1_sneg;
            r2_tmag <= f_div255(r1_ty);
            r2_tneg <= r1_tneg;
            r2_tl   <= tl_div[7:0];
            r2_bl   <= bl_div[7:0];
            r2_link <= r1_link;
            r2_btn  <= r1_btn;
        end
    end

    // ---------------- stage 3: quotient correction, mode mixing ----------------
    logic [15:0] db_div;
    logic [31:0] db_back;
    logic [31:0] db_rem;
    logic [15:0] db_q;
    logic [15:0] steer_in;
    t_side       side3;
    logic [2:0]  kind3;

    assign db_div   = DB_DIV[r_cfg_db];
    assign db_back  = r2_qe * db_div;
    assign db_rem   = {2'b0, r2_num} - db_back;
    // estimate is low by at most one
    assign db_q     = (db_rem >= {16'b0, db_div}) ? (r2_qe + 16'd1) : r2_qe;
    assign steer_in = (r_cfg_db == 7'd0) ? {1'b0, r2_av} : db_q;

    always_comb begin
        case (mode)
            MODE_COMBINED: kind3 = KIND_COMBINED;
            MODE_SEPARATE: kind3 = KIND_SEPARATE;
            MODE_THR_ONLY: kind3 = KIND_THR_ONLY;
            default:       kind3 = KIND_NONE;
        endcase
        side3.link = r2_link;
        side3.kind = r2_link ? kind3 : KIND_FAILSAFE;
        side3.btn  = r2_btn;
        side3.tl   = '0;
        side3.bl   = '0;
        if (mode == MODE_SEPARATE || mode == MODE_THR_ONLY) begin
            side3.tl = thr_inv ? (LEVEL_MAX - r2_tl) : r2_tl;
        end
        if (mode == MODE_SEPARATE) begin
            side3.bl = r2_bl;
        end
    end

    logic [15:0] r3_smag;
    logic        r3_sneg;
    logic [15:0] r3_tmag;
    logic        r3_tneg;
    t_side       r_side [3:PIPE_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_smag   <= steer_in;
            r3_sneg   <= r2_sneg;
            r3_tmag   <= r2_tmag;
            r3_tneg   <= r2_tneg;
        end
    end

    // sideband shift line through the expo and endpoint stages
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_side[3] <= side3;
        end
        for (int k = 4; k < PIPE_STAGES; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- stages 4 to 9: expo lanes ----------------
    logic [15:0] se_mag;
    logic        se_neg;
    logic [15:0] te_mag;
    logic        te_neg;

    rcm_expo u_steer_expo (
        .i_clk  (i_clk),
        .i_en   (en[9:4]),
        .i_mag  (r3_smag),
        .i_neg  (r3_sneg),
        .i_expo (r_cfg_sexpo),
        .o_mag  (se_mag),
        .o_neg  (se_neg)
    );

    rcm_expo u_thr_expo (
        .i_clk  (i_clk),
        .i_en   (en[9:4]),
        .i_mag  (r3_tmag),
        .i_neg  (r3_tneg),
        .i_expo (r_cfg_texpo),
        .o_mag  (te_mag),
        .o_neg  (te_neg)
    );

    // ---------------- stages 10 and 11: endpoints ----------------
    // steering inverts before the left/right pick, throttle inverts after
    logic signed [15:0] steer_val;
    logic signed [15:0] thr_val;

    rcm_endpoint u_steer_ep (
        .i_clk     (i_clk),
        .i_en      (en[11:10]),
        .i_mag     (se_mag),
        .i_neg     (se_neg ^ steer_inv),
        .i_flip    (1'b0),
        .i_pct_pos (r_cfg_endr),
        .i_pct_neg (r_cfg_endl),
        .o_value   (steer_val)
    );

    rcm_endpoint u_thr_ep (
        .i_clk     (i_clk),
        .i_en      (en[11:10]),
        .i_mag     (te_mag),
        .i_neg     (te_neg),
        .i_flip    (thr_inv),
        .i_pct_pos (r_cfg_tend),
        .i_pct_neg (r_cfg_bend),
        .o_value   (thr_val)
    );

    // ---------------- output: failsafe gating on the last stage ----------------
    t_side side_o;
    assign side_o = r_side[PIPE_STAGES-1];

    always_comb begin
        o_out_item = '0;
        if (side_o.link) begin
            o_out_item.steer_value     = steer_val;
            o_out_item.throttle_axis   = (side_o.kind == KIND_COMBINED) ? thr_val : 16'sd0;
            o_out_item.throttle_level  = side_o.tl;
            o_out_item.brake_level     = side_o.bl;
            o_out_item.result_kind     = side_o.kind;
            o_out_item.paddle_left_on  = side_o.btn[0] | side_o.btn[2];
            o_out_item.paddle_right_on = side_o.btn[1] | side_o.btn[3];
            o_out_item.buttons_out     = side_o.btn;
        end
    end

endmodule

// ===== rtl/rcm_checker.sv =====
// ----------------------------------------------------------------------------
// rcm_checker
// port-level checks on the mixer, attached to the top level by bind
// ----------------------------------------------------------------------------
module rcm_checker import rcm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_out_item  o_out_item
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("valid item after reset");

    // failsafe result carries nothing
    a_failsafe_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == KIND_FAILSAFE) |->
        (o_out_item.steer_value == 16'sd0 && o_out_item.buttons_out == 6'd0 &&
         o_out_item.throttle_level == 8'd0 && !o_out_item.paddle_left_on))
        else $error("failsafe item not cleared");

    // signed throttle only in combined mode
    a_axis_combined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind != KIND_COMBINED) |->
        (o_out_item.throttle_axis == 16'sd0))
        else $error("throttle axis outside combined mode");

    // paddles follow the passed-through buttons
    a_paddles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        (o_out_item.paddle_left_on == (o_out_item.buttons_out[0] | o_out_item.buttons_out[2]) &&
         o_out_item.paddle_right_on == (o_out_item.buttons_out[1] | o_out_item.buttons_out[3])))
        else $error("paddle flags disagree with buttons");

    // stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled item changed");

endmodule

bind rc_axis_trigger_mixer rcm_checker u_rcm_checker (.*);

// ===== test/rc_axis_trigger_mixer_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_axis_trigger_mixer_chk
// watches the config port and both item channels, predicts each mixed result
// and compares it field by field with what the mixer hands out
// ----------------------------------------------------------------------------
module rc_axis_trigger_mixer_chk import rcm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_cnt,
    output int         o_pending,
    output int         o_in_cnt,
    output int         o_out_cnt
);

    int unsigned deadband_pct;
    int          steer_expo_pct, thr_expo_pct;
    int unsigned end_left, end_right, thr_end, brk_end;
    logic [3:0]  mode_inv;
    t_out_item   mix_q[$];

    function automatic int apply_deadband(int v, int unsigned d);
        int t;
        if (d == 0) return v;
        t = (32768 * d) / 100;
        if (v > -t && v < t) return 0;
        if (v >= t) return ((v - t) * 32767) / (32768 - t);
        return ((v + t) * 32767) / (32768 - t);
    endfunction

    function automatic int apply_expo(int v, int e);
        longint x, cube, num, mag;
        if (e == 0) return v;
        x    = v;
        mag  = (e < 0) ? -e : e;
        cube = (x * x * x) / 32768;
        num  = x * 32768 * (100 - mag) + cube * e;
        return int'((num * 32767) / (longint'(100) * 1073741824));
    endfunction

    function automatic int apply_end(int v, int unsigned p);
        if (p >= 100) return v;
        return (v * int'(p)) / 100;
    endfunction

    function automatic int clamp_pct(logic [7:0] raw);
        int e;
        e = int'($signed(raw));
        if (e > 100) return 100;
        if (e < -100) return -100;
        return e;
    endfunction

    function automatic int unsigned cap_pct(logic [7:0] raw, int unsigned hi);
        int unsigned v;
        v = raw[6:0];
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_out_item mix_sample(t_in_item s);
        t_out_item   r;
        int          steer, axis;
        int unsigned tl, bl;
        r = '0;
        if (!s.link_up) return r;
        steer = int'(s.wheel_raw);
        steer = (steer >= 0) ? 32767 - steer : -32767 - steer;
        steer = apply_deadband(steer, deadband_pct);
        steer = apply_expo(steer, steer_expo_pct);
        if (mode_inv[2]) steer = -steer;
        steer = (steer >= 0) ? apply_end(steer, end_right) : apply_end(steer, end_left);
        axis = 0; tl = 0; bl = 0;
        case (mode_inv[1:0])
            MODE_COMBINED: begin
                axis = ((int'(s.gas_trigger) - int'(s.brake_trigger)) * 32767) / 255;
                axis = apply_expo(axis, thr_expo_pct);
                axis = (axis >= 0) ? apply_end(axis, thr_end) : apply_end(axis, brk_end);
                if (mode_inv[3]) axis = -axis;
                r.result_kind = KIND_COMBINED;
            end
            MODE_NONE: r.result_kind = KIND_NONE;
            default: begin
                tl = (s.gas_trigger * thr_end) / 100;
                if (mode_inv[3]) tl = 255 - tl;
                if (mode_inv[1:0] == MODE_SEPARATE) begin
                    bl = (s.brake_trigger * brk_end) / 100;
                    r.result_kind = KIND_SEPARATE;
                end else begin
                    r.result_kind = KIND_THR_ONLY;
                end
            end
        endcase
        r.steer_value     = steer[15:0];
        r.throttle_axis   = axis[15:0];
        r.throttle_level  = tl[7:0];
        r.brake_level     = bl[7:0];
        r.paddle_left_on  = s.button_bits[0] | s.button_bits[2];
        r.paddle_right_on = s.button_bits[1] | s.button_bits[3];
        r.buttons_out     = s.button_bits;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        o_fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_out_item w;
        if (!i_rst_n) begin
            deadband_pct = 0; steer_expo_pct = 0; thr_expo_pct = 0;
            end_left = 100; end_right = 100; thr_end = 100; brk_end = 100;
            mode_inv = '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEADBAND:   deadband_pct   = cap_pct(i_cfg_data, 99);
                    CFG_STEER_EXPO: steer_expo_pct = clamp_pct(i_cfg_data);
                    CFG_THR_EXPO:   thr_expo_pct   = clamp_pct(i_cfg_data);
                    CFG_END_LEFT:   end_left       = cap_pct(i_cfg_data, 100);
                    CFG_END_RIGHT:  end_right      = cap_pct(i_cfg_data, 100);
                    CFG_THR_END:    thr_end        = cap_pct(i_cfg_data, 100);
                    CFG_BRAKE_END:  brk_end        = cap_pct(i_cfg_data, 100);
                    CFG_MODE_INV:   mode_inv       = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                mix_q.push_back(mix_sample(i_in_item));
                o_in_cnt++;
            end
            if (i_out_valid && !i_out_stall) begin
                o_out_cnt++;
                if (mix_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    w = mix_q.pop_front();
                    if (i_out_item.steer_value !== w.steer_value)
                        report_mismatch("steer_value", i_out_item.steer_value, w.steer_value);
                    if (i_out_item.throttle_axis !== w.throttle_axis)
                        report_mismatch("throttle_axis", i_out_item.throttle_axis,
                                        w.throttle_axis);
                    if (i_out_item.throttle_level !== w.throttle_level)
                        report_mismatch("throttle_level", i_out_item.throttle_level,
                                        w.throttle_level);
                    if (i_out_item.brake_level !== w.brake_level)
                        report_mismatch("brake_level", i_out_item.brake_level, w.brake_level);
                    if (i_out_item.result_kind !== w.result_kind)
                        report_mismatch("result_kind", i_out_item.result_kind, w.result_kind);
                    if (i_out_item.paddle_left_on !== w.paddle_left_on)
                        report_mismatch("paddle_left_on", i_out_item.paddle_left_on,
                                        w.paddle_left_on);
                    if (i_out_item.paddle_right_on !== w.paddle_right_on)
                        report_mismatch("paddle_right_on", i_out_item.paddle_right_on,
                                        w.paddle_right_on);
                    if (i_out_item.buttons_out !== w.buttons_out)
                        report_mismatch("buttons_out", i_out_item.buttons_out, w.buttons_out);
                end
            end
            o_pending = mix_q.size();
        end
    end

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
        o_in_cnt   = 0;
        o_out_cnt  = 0;
    end

endmodule

// ===== test/rc_axis_trigger_mixer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_axis_trigger_mixer_tb
// drives wheel/trigger samples through the mixer under a series of register
// settings with random idling on both channels; the checker predicts results
// ----------------------------------------------------------------------------
module rc_axis_trigger_mixer_tb import rcm_pkg::*;;

    localparam int WATCHDOG   = 20000;
    localparam int N_PHASES   = 10;
    localparam int PER_PHASE  = 170;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [7:0] cfg_data = '0;

    int fail_cnt, pending, in_cnt, out_cnt;
    int idle_cycles;
    bit calm;       // no idling on either side
    bit hold_off;   // receiver holds off for a long stretch

    always #1 clk = ~clk;

    rc_axis_trigger_mixer u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    rc_axis_trigger_mixer_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_in_cnt(in_cnt), .o_out_cnt(out_cnt)
    );

    // receiver stalls in random bursts, or for a long stretch when asked
    always @(posedge clk) begin
        int n;
        if (hold_off) begin
            out_stall <= 1'b1;
            repeat (300) @(posedge clk);
            out_stall <= 1'b0;
            hold_off = 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            out_stall <= 1'b1;
            repeat (n) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("rc_axis_trigger_mixer test failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // offer one sample and hold it until taken; sender gaps come before it
    task automatic send_sample(t_in_item s);
        int n;
        if (!calm && $urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic t_in_item rand_sample();
        t_in_item s;
        int r;
        s.link_up = ($urandom_range(0, 9) != 0);
        r = $urandom_range(0, 7);
        if (r == 0)      s.wheel_raw = 16'sh7fff - 16'($urandom_range(0, 400));
        else if (r == 1) s.wheel_raw = 16'sh8000 + 16'($urandom_range(0, 400));
        else if (r == 2) s.wheel_raw = 16'($urandom_range(0, 400)) - 16'sd200;
        else             s.wheel_raw = 16'($urandom);
        s.gas_trigger   = 8'($urandom);
        s.brake_trigger = ($urandom_range(0, 3) == 0) ? s.gas_trigger : 8'($urandom);
        s.button_bits   = 6'($urandom);
        return s;
    endfunction

    // wait until every result is back, then stay idle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (PIPE_STAGES + 4) @(posedge clk);
    endtask

    task automatic write_all(logic [7:0] db, logic [7:0] se, logic [7:0] te,
                             logic [7:0] el, logic [7:0] er, logic [7:0] tend,
                             logic [7:0] bend, logic [7:0] mi);
        write_reg(CFG_DEADBAND, db);
        write_reg(CFG_STEER_EXPO, se);
        write_reg(CFG_THR_EXPO, te);
        write_reg(CFG_END_LEFT, el);
        write_reg(CFG_END_RIGHT, er);
        write_reg(CFG_THR_END, tend);
        write_reg(CFG_BRAKE_END, bend);
        write_reg(CFG_MODE_INV, mi);
    endtask

    initial begin
        t_in_item s;
        calm = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, wheel extremes, triggers, buttons, disconnect
        for (int b = 0; b < 6; b++) begin
            s = '0;
            s.link_up = 1'b1;
            s.button_bits = 6'(1 << b);
            s.wheel_raw = (b % 2) ? 16'sh7fff : 16'sh8000;
            s.gas_trigger = (b < 3) ? 8'hff : 8'h00;
            s.brake_trigger = (b < 3) ? 8'h00 : 8'hff;
            send_sample(s);
        end
        s = '1;          send_sample(s);
        s.link_up = 0;   send_sample(s);
        s = '0; s.link_up = 1; s.wheel_raw = 16'sh0000; send_sample(s);
        s.wheel_raw = 16'shffff; s.gas_trigger = 8'h80; s.brake_trigger = 8'h80;
        send_sample(s);
        s.wheel_raw = 16'sh8001; s.gas_trigger = 8'h01; send_sample(s);
        s.wheel_raw = 16'sh7ffe; s.brake_trigger = 8'hfe; s.button_bits = 6'h3f;
        send_sample(s);
        drain();

        // phases under different settings, extremes and out-of-range values included
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: write_all(8'd99, 8'd100, 8'h9c, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
                1: write_all(8'd127, 8'h80, 8'h7f, 8'd127, 8'd100, 8'd100, 8'd127, 8'd12);
                2: write_all(8'd0, 8'd0, 8'd0, 8'd100, 8'd100, 8'd100, 8'd100, 8'd2);
                3: write_all(8'd50, 8'hce, 8'd37, 8'd73, 8'd41, 8'd99, 8'd1, 8'd8);
                4: write_all(8'd1, 8'd1, 8'hff, 8'd99, 8'd1, 8'd50, 8'd50, 8'd15);
                5: write_all(8'd10, 8'd101, 8'h9b, 8'd100, 8'd100, 8'd200, 8'd0, 8'd9);
                default: write_all(8'($urandom_range(0, 127)), 8'($urandom),
                                   8'($urandom), 8'($urandom_range(0, 127)),
                                   8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)),
                                   8'($urandom_range(0, 127)), 8'($urandom_range(0, 15)));
            endcase
            // long receiver hold-off while samples keep coming
            if (ph == 2) hold_off = 1'b1;
            if (ph == N_PHASES - 1) calm = 1'b1;
            for (int i = 0; i < PER_PHASE; i++) send_sample(rand_sample());
            drain();
        end

        $display("covered %0d samples in %0d register settings, all modes and inverts,",
                 in_cnt, N_PHASES + 1);
        $display("disconnects, wheel and trigger extremes, idle bursts and a long hold-off");
        if (fail_cnt == 0 && pending == 0 && out_cnt == in_cnt)
            $display("rc_axis_trigger_mixer test passed");
        else
            $display("rc_axis_trigger_mixer test failed");
        $finish;
    end

endmodule
